>>> hdl/iostk_pkg.sv
// ----------------------------------------------------------------------------
// iostk_pkg - shared types and constants for the indexed operand stack
// Sizes, command and status codes, and the control word for the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package iostk_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int WORD_W      = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int IDX_W       = 10;
  localparam int CMD_W       = 4;
  localparam int STAT_W      = 2;

  localparam int TREE_GRP    = 16;
  localparam int TREE_NGRP   = (STACK_DEPTH + TREE_GRP - 1) / TREE_GRP;

  localparam logic [CMD_W-1:0] CMD_READ     = 4'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE    = 4'd1;
  localparam logic [CMD_W-1:0] CMD_COPY     = 4'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_INSERT   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_PUSH     = 4'd5;
  localparam logic [CMD_W-1:0] CMD_POP      = 4'd6;
  localparam logic [CMD_W-1:0] CMD_POP_IDX  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_READ_TOP = 4'd8;
  localparam logic [CMD_W-1:0] CMD_SET_TOP  = 4'd9;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd3;

  typedef enum logic [1:0] {
    COP_HOLD,
    COP_LOAD,
    COP_DOWN,
    COP_UP
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [CNT_W-1:0]    lo;
    logic [CNT_W-1:0]    hi;
    logic [ADDR_W-1:0]   rd_addr;
    logic [WORD_W-1:0]   wdata;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> hdl/iostk_cell.sv
// ----------------------------------------------------------------------------
// iostk_cell - one stack entry
// Holds one word, loads, shifts from either neighbor, and offers its word
// to the read tree when its position is addressed.
// ----------------------------------------------------------------------------
`default_nettype none

module iostk_cell (
  input  wire                              clk,
  input  wire  [iostk_pkg::ADDR_W-1:0]     cell_idx,
  input  iostk_pkg::cell_ctl_t             ctl,
  input  wire  [iostk_pkg::WORD_W-1:0]     upper_word,
  input  wire  [iostk_pkg::WORD_W-1:0]     lower_word,
  output logic [iostk_pkg::WORD_W-1:0]     word,
  output logic [iostk_pkg::WORD_W-1:0]     rd_word
);
  import iostk_pkg::*;

  logic [CNT_W-1:0]  pos;
  logic              in_range;
  logic              at_lo;
  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;
  logic [WORD_W-1:0] rd_word_r;

  assign pos      = CNT_W'(cell_idx);
  assign in_range = (pos >= ctl.lo) && (pos < ctl.hi);
  assign at_lo    = (pos == ctl.lo);

  always_comb begin
    word_nxt = word_r;
    unique case (ctl.op)
      COP_HOLD: word_nxt = word_r;
      COP_LOAD: if (in_range) word_nxt = ctl.wdata;
      COP_DOWN: if (in_range) word_nxt = upper_word;
      COP_UP: begin
        if (at_lo && in_range) word_nxt = ctl.wdata;
        else if (in_range)     word_nxt = lower_word;
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r    <= word_nxt;
    rd_word_r <= (cell_idx == ctl.rd_addr) ? word_r : '0;
  end

  assign word    = word_r;
  assign rd_word = rd_word_r;

endmodule

`default_nettype wire

>>> hdl/iostk_or_tree.sv
// ----------------------------------------------------------------------------
// iostk_or_tree - registered read tree
// Merges the masked words of all cells in two registered levels.
// ----------------------------------------------------------------------------
`default_nettype none

module iostk_or_tree (
  input  wire                              clk,
  input  wire  [iostk_pkg::WORD_W-1:0]     words [iostk_pkg::STACK_DEPTH],
  output logic [iostk_pkg::WORD_W-1:0]     rd_data
);
  import iostk_pkg::*;

  logic [WORD_W-1:0] grp_nxt [TREE_NGRP];
  logic [WORD_W-1:0] grp_r   [TREE_NGRP];
  logic [WORD_W-1:0] top_nxt;
  logic [WORD_W-1:0] top_r;

  always_comb begin
    for (int g = 0; g < TREE_NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < TREE_GRP; j++) begin
        if (g * TREE_GRP + j < STACK_DEPTH) grp_nxt[g] = grp_nxt[g] | words[g * TREE_GRP + j];
      end
    end
  end

  always_comb begin
    top_nxt = '0;
    for (int g = 0; g < TREE_NGRP; g++) top_nxt = top_nxt | grp_r[g];
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
    top_r <= top_nxt;
  end

  assign rd_data = top_r;

endmodule

`default_nettype wire

>>> hdl/indexed_operand_stack.sv
// ----------------------------------------------------------------------------
// indexed_operand_stack - operand stack with indexed access, insert, delete
// A command is accepted only while idle; it passes the cell read, two read-tree
// levels and the execute step in turn, and its result strobe is registered
// from the execute step. No new command is taken until it is done.
// Reset clears the depth and the null word; entry contents stay unknown.
// Results are strobed for one cycle and are not held for the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_operand_stack (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire  [iostk_pkg::CMD_W-1:0]       in_cmd,
  input  wire  [iostk_pkg::IDX_W-1:0]       in_index,
  input  wire  [iostk_pkg::ADDR_W-1:0]      in_source_index,
  input  wire  [iostk_pkg::WORD_W-1:0]      in_value,
  output logic                              out_valid,
  output logic [iostk_pkg::WORD_W-1:0]      out_read_value,
  output logic [iostk_pkg::CNT_W-1:0]       out_depth,
  output logic [iostk_pkg::STAT_W-1:0]      out_status,
  input  wire                               cfg_we,
  input  wire  [iostk_pkg::WORD_W-1:0]      cfg_wdata
);
  import iostk_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_T1   = 3'd2;
  localparam logic [2:0] S_T2   = 3'd3;
  localparam logic [2:0] S_EX   = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [WORD_W-1:0]  null_r;

  cell_op_t           op_r, op_nxt;
  logic [CNT_W-1:0]   lo_r, lo_nxt;
  logic [CNT_W-1:0]   hi_r, hi_nxt;
  logic [ADDR_W-1:0]  rd_addr_r, rd_addr_nxt;
  logic [WORD_W-1:0]  wdata_r, wdata_nxt;
  logic               use_tree_r, use_tree_nxt;
  logic               rv_en_r, rv_en_nxt;
  logic [STAT_W-1:0]  status_r, status_nxt;
  logic [CNT_W-1:0]   new_cnt_r, new_cnt_nxt;

  logic               out_valid_r;
  logic [WORD_W-1:0]  out_read_value_r;
  logic [STAT_W-1:0]  out_status_r;

  logic               accept;
  logic               idx_neg;
  logic               idx_ok;
  logic               src_ok;
  logic               empty;
  logic [CNT_W-1:0]   cnt_m1;
  logic [CNT_W-1:0]   idx_c;
  logic [IDX_W-1:0]   drop;

  cell_ctl_t          ctl;
  logic [WORD_W-1:0]  words    [STACK_DEPTH];
  logic [WORD_W-1:0]  rd_words [STACK_DEPTH];
  logic [WORD_W-1:0]  tree_data;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign idx_neg = in_index[IDX_W-1];
  assign idx_c   = CNT_W'(in_index);
  assign cnt_m1  = count_r - CNT_W'(1);
  assign empty   = (count_r == '0);
  assign idx_ok  = !idx_neg && (in_index < IDX_W'(count_r));
  assign src_ok  = (CNT_W'(in_source_index) < count_r);
  assign drop    = ~in_index;

  always_comb begin
    op_nxt       = COP_HOLD;
    lo_nxt       = '0;
    hi_nxt       = '0;
    rd_addr_nxt  = '0;
    wdata_nxt    = in_value;
    use_tree_nxt = 1'b0;
    rv_en_nxt    = 1'b0;
    status_nxt   = ST_OK;
    new_cnt_nxt  = count_r;
    unique case (in_cmd)
      CMD_READ: begin
        if (idx_ok) begin
          rd_addr_nxt = in_index[ADDR_W-1:0];
          rv_en_nxt   = 1'b1;
        end else begin
          status_nxt = ST_BAD_INDEX;
        end
      end
      CMD_WRITE: begin
        if (idx_ok) begin
          op_nxt = COP_LOAD;
          lo_nxt = idx_c;
          hi_nxt = idx_c + CNT_W'(1);
        end else begin
          status_nxt = ST_BAD_INDEX;
        end
      end
      CMD_COPY: begin
        if (idx_ok && src_ok) begin
          op_nxt       = COP_LOAD;
          lo_nxt       = idx_c;
          hi_nxt       = idx_c + CNT_W'(1);
          rd_addr_nxt  = in_source_index;
          use_tree_nxt = 1'b1;
        end else begin
          status_nxt = ST_BAD_INDEX;
        end
      end
      CMD_DELETE: begin
        if (empty) status_nxt = ST_UNDERFLOW;
        else if (!idx_ok) status_nxt = ST_BAD_INDEX;
        else begin
          op_nxt      = COP_DOWN;
          lo_nxt      = idx_c;
          hi_nxt      = cnt_m1;
          new_cnt_nxt = cnt_m1;
        end
      end
      CMD_INSERT: begin
        if (empty) status_nxt = ST_UNDERFLOW;
        else if (!idx_ok) status_nxt = ST_BAD_INDEX;
        else begin
          op_nxt       = COP_UP;
          lo_nxt       = idx_c;
          hi_nxt       = count_r;
          rd_addr_nxt  = cnt_m1[ADDR_W-1:0];
          use_tree_nxt = 1'b1;
        end
      end
      CMD_PUSH: begin
        if (count_r >= CNT_W'(STACK_DEPTH)) status_nxt = ST_OVERFLOW;
        else begin
          op_nxt      = COP_LOAD;
          lo_nxt      = count_r;
          hi_nxt      = count_r + CNT_W'(1);
          new_cnt_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_POP: begin
        if (empty) status_nxt = ST_UNDERFLOW;
        else begin
          rd_addr_nxt = cnt_m1[ADDR_W-1:0];
          rv_en_nxt   = 1'b1;
          new_cnt_nxt = cnt_m1;
        end
      end
      CMD_POP_IDX: begin
        if (empty) status_nxt = ST_UNDERFLOW;
        else if (idx_neg || (in_index >= IDX_W'(cnt_m1))) status_nxt = ST_BAD_INDEX;
        else begin
          op_nxt       = COP_LOAD;
          lo_nxt       = idx_c;
          hi_nxt       = idx_c + CNT_W'(1);
          rd_addr_nxt  = cnt_m1[ADDR_W-1:0];
          use_tree_nxt = 1'b1;
          rv_en_nxt    = 1'b1;
          new_cnt_nxt  = cnt_m1;
        end
      end
      CMD_READ_TOP: begin
        if (idx_ok) begin
          rd_addr_nxt = cnt_m1[ADDR_W-1:0] - in_index[ADDR_W-1:0];
          rv_en_nxt   = 1'b1;
        end else begin
          status_nxt = ST_BAD_INDEX;
        end
      end
      CMD_SET_TOP: begin
        if (!idx_neg) begin
          if (in_index > IDX_W'(STACK_DEPTH)) status_nxt = ST_OVERFLOW;
          else begin
            op_nxt      = COP_LOAD;
            lo_nxt      = count_r;
            hi_nxt      = idx_c;
            wdata_nxt   = null_r;
            new_cnt_nxt = idx_c;
          end
        end else begin
          if (drop > IDX_W'(count_r)) status_nxt = ST_UNDERFLOW;
          else new_cnt_nxt = count_r - CNT_W'(drop);
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_RD;
      S_RD:    state_nxt = S_T1;
      S_T1:    state_nxt = S_T2;
      S_T2:    state_nxt = S_EX;
      S_EX:    state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      null_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_EX);
      if (cfg_we) null_r <= cfg_wdata;
      if (state_r == S_EX) count_r <= new_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= op_nxt;
      lo_r       <= lo_nxt;
      hi_r       <= hi_nxt;
      rd_addr_r  <= rd_addr_nxt;
      wdata_r    <= wdata_nxt;
      use_tree_r <= use_tree_nxt;
      rv_en_r    <= rv_en_nxt;
      status_r   <= status_nxt;
      new_cnt_r  <= new_cnt_nxt;
    end
    if (state_r == S_EX) begin
      out_read_value_r <= rv_en_r ? tree_data : '0;
      out_status_r     <= status_r;
    end
  end

  always_comb begin
    ctl.op      = (state_r == S_EX) ? op_r : COP_HOLD;
    ctl.lo      = lo_r;
    ctl.hi      = hi_r;
    ctl.rd_addr = rd_addr_r;
    ctl.wdata   = use_tree_r ? tree_data : wdata_r;
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    iostk_cell u_cell (
      .clk        (clk),
      .cell_idx   (ADDR_W'(i)),
      .ctl        (ctl),
      .upper_word (words[(i + 1) % STACK_DEPTH]),
      .lower_word (words[(i + STACK_DEPTH - 1) % STACK_DEPTH]),
      .word       (words[i]),
      .rd_word    (rd_words[i])
    );
  end

  iostk_or_tree u_tree (
    .clk     (clk),
    .words   (rd_words),
    .rd_data (tree_data)
  );

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_depth      = count_r;
  assign out_status     = out_status_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_depth <= CNT_W'(STACK_DEPTH)))
    else $error("depth beyond stack size");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_strobe_after_ex: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_EX))
    else $error("result strobe without execute step");

  a_error_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_depth == $past(count_r)))
    else $error("failed command changed depth");

  a_error_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_read_value == '0))
    else $error("failed command returned a word");

endmodule

`default_nettype wire
